// File: src/distance_key_matte_top_macros.svh
// Assertion macros for the distance key matte block
`ifndef DISTANCE_KEY_MATTE_TOP_MACROS_SVH
`define DISTANCE_KEY_MATTE_TOP_MACROS_SVH

// property that must hold whenever reset is released
`define DKM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the next cycle
`define DKM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: src/dkm_pkg.sv
// Package: widths and stage depths for the distance key matte
`timescale 1ns / 1ps
package dkm_pkg;
  localparam int unsigned ChW   = 16;
  localparam int unsigned DiffW = 17;
  localparam int unsigned SumW  = 34;
  localparam int unsigned DistW = 17;
  localparam int unsigned SqrtSteps = 17;  // one result bit per stage
  localparam int unsigned DivSteps  = 16;  // one quotient bit per stage

  typedef enum logic {
    REG_TOLERANCE = 1'b0,
    REG_FALLOFF   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ChW-1:0] tol;
    logic [ChW-1:0] fo;
    logic [ChW-1:0] alpha;
  } side_t;
endpackage

// File: src/dkm_sqrt_pipe.sv
// Pipelined restoring square root, one result bit per stage, with sideband
`timescale 1ns / 1ps
module dkm_sqrt_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [dkm_pkg::SumW-1:0]     sum_i,
  input  dkm_pkg::side_t               side_i,
  output logic                         valid_o,
  output logic [dkm_pkg::DistW-1:0]    dist_o,
  output dkm_pkg::side_t               side_o
);
  import dkm_pkg::*;

  logic [SqrtSteps:0]                 vld_q;
  logic [SqrtSteps:0][SumW-1:0]       rem_q;
  logic [SqrtSteps:0][DistW-1:0]      root_q;
  logic [SqrtSteps:0][SumW-1:0]       val_q;
  side_t [SqrtSteps:0]                side_q;

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign val_q[0]  = sum_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_stage
    logic [SumW+1:0] trial;
    logic [SumW+1:0] rem_sh;
    logic [SumW-1:0] rem_d;
    logic [DistW-1:0] root_d;
    always_comb begin
      // bring down the next two radicand bits
      rem_sh = {rem_q[s], val_q[s][SumW-1 -: 2]};
      trial  = {{(SumW+2-DistW-2){1'b0}}, root_q[s], 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = SumW'(rem_sh - trial);
        root_d = {root_q[s][DistW-2:0], 1'b1};
      end else begin
        rem_d  = SumW'(rem_sh);
        root_d = {root_q[s][DistW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        val_q[s+1]  <= {val_q[s][SumW-3:0], 2'b00};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign dist_o  = root_q[SqrtSteps];
  assign side_o  = side_q[SqrtSteps];
endmodule

// File: src/dkm_ramp_pipe.sv
// Band test and pipelined restoring divider for the alpha ramp
`timescale 1ns / 1ps
module dkm_ramp_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [dkm_pkg::DistW-1:0]    dist_i,
  input  dkm_pkg::side_t               side_i,
  output logic                         valid_o,
  output logic [dkm_pkg::ChW-1:0]      alpha_o
);
  import dkm_pkg::*;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_RAMP  = 2'd1,
    SEL_ALPHA = 2'd2
  } sel_e;

  // entry stage: classify distance against the band
  logic       vld0_q;
  sel_e       sel0_q;
  logic [ChW-1:0] num0_q;
  logic [ChW-1:0] fo0_q;
  logic [ChW-1:0] a0_q;
  logic [DistW-1:0] hi_w;
  logic [DistW-1:0] off_w;
  sel_e       sel_w;

  always_comb begin
    hi_w  = DistW'(side_i.tol) + DistW'(side_i.fo);
    off_w = dist_i - DistW'(side_i.tol);
    if (dist_i < DistW'(side_i.tol)) sel_w = SEL_ZERO;
    else if (dist_i < hi_w)          sel_w = SEL_RAMP;
    else                              sel_w = SEL_ALPHA;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv_i) begin
      vld0_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sel0_q <= sel_w;
      num0_q <= off_w[ChW-1:0];  // below falloff inside the band
      fo0_q  <= side_i.fo;
      a0_q   <= side_i.alpha;
    end
  end

  // divider: (num << 16) / fo, one quotient bit per stage
  logic [DivSteps:0]              vld_q;
  sel_e [DivSteps:0]              sel_q;
  logic [DivSteps:0][ChW-1:0]     rem_q;
  logic [DivSteps:0][ChW-1:0]     quo_q;
  logic [DivSteps:0][ChW-1:0]     fo_q;
  logic [DivSteps:0][ChW-1:0]     a_q;

  assign vld_q[0] = vld0_q;
  assign sel_q[0] = sel0_q;
  assign rem_q[0] = num0_q;
  assign quo_q[0] = '0;
  assign fo_q[0]  = fo0_q;
  assign a_q[0]   = a0_q;

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    logic [ChW:0]   sh;
    logic [ChW-1:0] rem_d;
    logic           bit_d;
    always_comb begin
      sh = {rem_q[s], 1'b0};
      if (sh >= {1'b0, fo_q[s]}) begin
        rem_d = ChW'(sh - {1'b0, fo_q[s]});
        bit_d = 1'b1;
      end else begin
        rem_d = sh[ChW-1:0];
        bit_d = 1'b0;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sel_q[s+1] <= sel_q[s];
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= {quo_q[s][ChW-2:0], bit_d};
        fo_q[s+1]  <= fo_q[s];
        a_q[s+1]   <= a_q[s];
      end
    end
  end

  logic [ChW-1:0] ramp_w;
  logic [ChW-1:0] a_w;
  assign ramp_w = quo_q[DivSteps];
  assign a_w    = a_q[DivSteps];

  always_comb begin
    case (sel_q[DivSteps])
      SEL_ZERO: alpha_o = '0;
      SEL_RAMP: alpha_o = (ramp_w < a_w) ? ramp_w : a_w;
      default:  alpha_o = a_w;
    endcase
  end
  assign valid_o = vld_q[DivSteps];
endmodule

// File: src/distance_key_matte_top.sv
// Top level of the distance key matte pipeline
//
// channel  | direction | handshake
// input    | in        | in_valid_i / in_stall_o
// output   | out       | out_valid_o / out_stall_i
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One pixel per cycle while the output is not stalled; 36 register stages
// (squares, 17 root stages, band test, 16 divider stages, output register).
// The root and divider stages set the depth; each does one bit.
// The whole pipe advances unless the output register holds an item
// that is stalled; then the input is stalled too and nothing moves.
// Reset clears valid bits and loads tolerance and falloff with 6554.
`timescale 1ns / 1ps
`include "distance_key_matte_top_macros.svh"
module distance_key_matte_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [dkm_pkg::ChW-1:0]   cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dkm_pkg::ChW-1:0]   image_r_i,
  input  logic [dkm_pkg::ChW-1:0]   image_g_i,
  input  logic [dkm_pkg::ChW-1:0]   image_b_i,
  input  logic [dkm_pkg::ChW-1:0]   image_alpha_i,
  input  logic [dkm_pkg::ChW-1:0]   key_r_i,
  input  logic [dkm_pkg::ChW-1:0]   key_g_i,
  input  logic [dkm_pkg::ChW-1:0]   key_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dkm_pkg::ChW-1:0]   matte_alpha_o
);
  import dkm_pkg::*;

  logic [ChW-1:0] tol_q, fo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ChW'(6554);
      fo_q  <= ChW'(6554);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TOLERANCE: tol_q <= cfg_data_i;
        REG_FALLOFF:   fo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic [ChW-1:0] out_q;
  logic adv;
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage: absolute differences squared
  logic vsq_q;
  logic [SumW-1:0] sqr_q, sqg_q, sqb_q;
  side_t sdsq_q;
  logic [ChW-1:0] dr, dg, db;
  logic [2*ChW-1:0] pr, pg, pb;
  assign dr = (image_r_i >= key_r_i) ? image_r_i - key_r_i : key_r_i - image_r_i;
  assign dg = (image_g_i >= key_g_i) ? image_g_i - key_g_i : key_g_i - image_g_i;
  assign db = (image_b_i >= key_b_i) ? image_b_i - key_b_i : key_b_i - image_b_i;
  assign pr = dr * dr;
  assign pg = dg * dg;
  assign pb = db * db;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vsq_q <= 1'b0;
    else if (adv) vsq_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqr_q  <= SumW'(pr);
      sqg_q  <= SumW'(pg);
      sqb_q  <= SumW'(pb);
      sdsq_q <= '{tol: tol_q, fo: fo_q, alpha: image_alpha_i};
    end
  end

  logic [SumW-1:0] sum_w;
  assign sum_w = sqr_q + sqg_q + sqb_q;

  logic rt_vld;
  logic [DistW-1:0] root_dist;
  side_t rt_side;
  dkm_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(vsq_q), .sum_i(sum_w),
    .side_i(sdsq_q), .valid_o(rt_vld), .dist_o(root_dist), .side_o(rt_side)
  );

  logic rp_vld;
  logic [ChW-1:0] alpha;
  dkm_ramp_pipe u_ramp (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(rt_vld), .dist_i(root_dist),
    .side_i(rt_side), .valid_o(rp_vld), .alpha_o(alpha)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= rp_vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= alpha;
  end

  assign out_valid_o   = out_vld_q;
  assign matte_alpha_o = out_q;

  `DKM_ASSERT(a_stall_only_when_full, !in_stall_o || out_valid_o, "input stalled with empty output")
  `DKM_ASSERT_NEXT(a_hold_valid, out_valid_o && out_stall_i, out_valid_o, "stalled item lost")
  `DKM_ASSERT_NEXT(a_hold_data, out_valid_o && out_stall_i, $stable(matte_alpha_o), "stalled item changed")
endmodule
